// ----- hw/rtl/psap_pkg.sv -----
package psap_pkg;

   localparam int COORD_W       = 32;
   localparam int OFFSET_W      = 32;
   localparam int BAND_W        = 16;
   localparam int AXIS_W        = 2;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int JOB_DEPTH     = 2;
   localparam int RSP_DEPTH     = 2;

   // Side of plane, formed exactly: one bit above the wider of coordinate and offset.
   localparam int SIDE_W = ((COORD_W > OFFSET_W) ? COORD_W : OFFSET_W) + 1;

   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_AXIS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_BAND    = 2'd2;

   localparam logic OP_SEED   = 1'b0;
   localparam logic OP_VERTEX = 1'b1;

   typedef enum logic [1:0] {
      CLS_ON    = 2'd0,
      CLS_ABOVE = 2'd1,
      CLS_BELOW = 2'd2
   } class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_EMIT_X,
      ST_EMIT_V
   } back_state_type;

   typedef struct packed {
      logic                       opcode;
      logic signed [COORD_W-1:0]  vertex_x;
      logic signed [COORD_W-1:0]  vertex_y;
      logic signed [COORD_W-1:0]  vertex_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  point_x;
      logic signed [COORD_W-1:0]  point_y;
      logic signed [COORD_W-1:0]  point_z;
      logic                       to_below_list;
      logic                       to_above_list;
      logic                       last_of_run;
   } rsp_type;

   // One classified vertex handed from front to back. Points are indexed x, y, z = 0, 1, 2.
   typedef struct packed {
      logic                       crossing;
      logic                       to_below;
      logic                       to_above;
      logic [2:0][COORD_W-1:0]    cur_pt;
      logic [2:0][COORD_W-1:0]    prev_pt;
      logic [SIDE_W-1:0]          mag_a;
      logic [SIDE_W-1:0]          mag_b;
   } job_type;

endpackage

// ----- hw/rtl/polygon_split_by_axis_plane_core.sv -----
// Axis-aligned plane splitter, streamed one polygon vertex per beat.
// Input: a queue-style channel (req_push / req_full) carrying opcode and one vertex.
// A seed beat loads the polygon's closing vertex and yields nothing; a vertex beat
// yields one result, or two when the edge from the previous vertex crosses the plane
// (the intersection point for both lists first, then the vertex itself).
// Results: a queue-style channel (rsp_empty / rsp_pop); last_of_run marks the final
// result of a vertex. Configuration: csr_valid / csr_ready with register index and data;
// ready is always high. Writes must be made only while the block is idle; the block
// itself does not enforce this. A vertex that does not cross goes from the job queue
// straight to its result. A crossing vertex first runs the serial restoring divider,
// which produces one edge-parameter bit per cycle; then one shared multiplier pair
// interpolates x, y and z in turn, each through a multiply step and an add step.
// A two-entry job queue lets the front keep accepting while the back works; a
// two-entry result queue holds results while the receiver stalls, and the back end
// waits when it is full. Reset clears the previous vertex to the origin on the plane,
// restores register defaults and empties both queues.
module polygon_split_by_axis_plane_core #(
   parameter int FRAC_BITS = psap_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  psap_pkg::req_type                 req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output psap_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [psap_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [psap_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int JOB_W = $bits(psap_pkg::job_type);
   localparam int RSP_W = $bits(psap_pkg::rsp_type);

   // Front to job queue.
   logic              job_push;
   logic              job_full;
   psap_pkg::job_type job_in;

   // Job queue to back.
   logic              job_empty;
   logic              job_pop;
   psap_pkg::job_type job_out;

   // Back to result queue.
   logic              rsp_push;
   logic              rsp_full;
   psap_pkg::rsp_type rsp_in;

   psap_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .job_push  (job_push),
      .job_full  (job_full),
      .job_data  (job_in)
   );

   psap_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (psap_pkg::JOB_DEPTH)
   ) u_job_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .full    (job_full),
      .wr_data (job_in),
      .pop     (job_pop),
      .empty   (job_empty),
      .rd_data (job_out)
   );

   psap_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .job_data  (job_out),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full),
      .rsp_data  (rsp_in)
   );

   // The result queue parts the back end from the receiver.
   psap_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (psap_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .full    (rsp_full),
      .wr_data (rsp_in),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_data)
   );

endmodule

// ----- hw/rtl/psap_fifo.sv -----
module psap_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hw/rtl/psap_front.sv -----
module psap_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  psap_pkg::req_type                     req_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [psap_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [psap_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic                                  job_push,
   input  logic                                  job_full,
   output psap_pkg::job_type                     job_data
);

   localparam int CW = psap_pkg::COORD_W;
   localparam int SW = psap_pkg::SIDE_W;

   logic [psap_pkg::AXIS_W-1:0]          split_axis_ff;
   logic signed [psap_pkg::OFFSET_W-1:0] plane_offset_ff;
   logic [psap_pkg::BAND_W-1:0]          zero_band_ff;

   logic [2:0][CW-1:0]    prev_pt_ff;
   psap_pkg::class_type   prev_class_ff;

   logic [2:0][CW-1:0]    cur_pt;
   logic signed [SW-1:0]  side_a;
   logic signed [SW-1:0]  side_b;
   logic [SW-1:0]         mag_a;
   logic [SW-1:0]         mag_b;
   psap_pkg::class_type   cls_b;
   logic                  accept;

   function automatic logic signed [SW-1:0] side_of(
      input logic [2:0][CW-1:0]             pt,
      input logic [psap_pkg::AXIS_W-1:0]    axis,
      input logic signed [psap_pkg::OFFSET_W-1:0] offset
   );
      logic signed [CW-1:0] c;
      unique case (axis)
         psap_pkg::AXIS_X: c = pt[0];
         psap_pkg::AXIS_Y: c = pt[1];
         default:          c = pt[2];
      endcase
      return SW'(c) - SW'(offset);
   endfunction

   function automatic logic [SW-1:0] mag_of(input logic signed [SW-1:0] s);
      return s[SW-1] ? SW'(-s) : SW'(s);
   endfunction

   assign cur_pt    = {req_data.vertex_z, req_data.vertex_y, req_data.vertex_x};
   assign side_b    = side_of(cur_pt, split_axis_ff, plane_offset_ff);
   assign side_a    = side_of(prev_pt_ff, split_axis_ff, plane_offset_ff);
   assign mag_b     = mag_of(side_b);
   assign mag_a     = mag_of(side_a);

   always_comb begin
      if (side_b == '0 || mag_b < SW'(zero_band_ff)) begin
         cls_b = psap_pkg::CLS_ON;
      end else if (side_b[SW-1]) begin
         cls_b = psap_pkg::CLS_BELOW;
      end else begin
         cls_b = psap_pkg::CLS_ABOVE;
      end
   end

   assign req_full  = job_full;
   assign accept    = req_push && !job_full;
   assign csr_ready = 1'b1;
   assign job_push  = accept && (req_data.opcode == psap_pkg::OP_VERTEX);

   always_comb begin
      job_data.crossing =
         (cls_b == psap_pkg::CLS_ABOVE && prev_class_ff == psap_pkg::CLS_BELOW)
         || (cls_b == psap_pkg::CLS_BELOW && prev_class_ff == psap_pkg::CLS_ABOVE);
      job_data.to_below = (cls_b != psap_pkg::CLS_ABOVE);
      job_data.to_above = (cls_b != psap_pkg::CLS_BELOW);
      job_data.cur_pt   = cur_pt;
      job_data.prev_pt  = prev_pt_ff;
      job_data.mag_a    = mag_a;
      job_data.mag_b    = mag_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_axis_ff   <= psap_pkg::AXIS_X;
         plane_offset_ff <= '0;
         zero_band_ff    <= psap_pkg::BAND_W'(1);
         prev_pt_ff      <= '0;
         prev_class_ff   <= psap_pkg::CLS_ON;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               psap_pkg::CSR_SPLIT_AXIS:   split_axis_ff   <= csr_data[psap_pkg::AXIS_W-1:0];
               psap_pkg::CSR_PLANE_OFFSET: plane_offset_ff <= csr_data[psap_pkg::OFFSET_W-1:0];
               psap_pkg::CSR_ZERO_BAND:    zero_band_ff    <= csr_data[psap_pkg::BAND_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            prev_pt_ff    <= cur_pt;
            prev_class_ff <= cls_b;
         end
      end
   end

endmodule

// ----- hw/rtl/psap_back.sv -----
module psap_back #(
   parameter int FRAC_BITS = psap_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_empty,
   output logic               job_pop,
   input  psap_pkg::job_type  job_data,
   output logic               rsp_push,
   input  logic               rsp_full,
   output psap_pkg::rsp_type  rsp_data
);

   localparam int CW    = psap_pkg::COORD_W;
   localparam int DEN_W = psap_pkg::SIDE_W + 1;
   localparam int HI_W  = CW + 1 - FRAC_BITS;
   localparam int PH_W  = HI_W + FRAC_BITS;
   localparam int PL_W  = 2 * FRAC_BITS;
   localparam int SUM_W = CW + 2;
   localparam int CNT_W = $clog2(FRAC_BITS);

   psap_pkg::back_state_type state_ff, state_in;
   psap_pkg::job_type        job_ff;

   logic [DEN_W-1:0]     rem_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [FRAC_BITS-1:0] t_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [1:0]           comp_ff;
   logic [PH_W-1:0]      prod_hi_ff;
   logic [PL_W-1:0]      prod_lo_ff;
   logic                 neg_ff;
   logic [2:0][CW-1:0]   point_ff;

   logic [DEN_W:0]        rem_sh;
   logic                  rem_ge;
   logic signed [CW-1:0]  comp_a;
   logic signed [CW-1:0]  comp_b;
   logic signed [CW:0]    diff;
   logic [CW:0]           diff_mag;
   logic [SUM_W-1:0]      prod;
   logic signed [SUM_W-1:0] lerp;

   assign rem_sh   = {rem_ff, 1'b0};
   assign rem_ge   = (rem_sh >= {1'b0, den_ff});
   assign comp_a   = job_ff.prev_pt[comp_ff];
   assign comp_b   = job_ff.cur_pt[comp_ff];
   assign diff     = (CW + 1)'(comp_b) - (CW + 1)'(comp_a);
   assign diff_mag = diff[CW] ? (CW + 1)'(-diff) : (CW + 1)'(diff);
   assign prod     = SUM_W'(prod_hi_ff) + SUM_W'(prod_lo_ff >> FRAC_BITS);
   assign lerp     = neg_ff ? SUM_W'(comp_a) - signed'(prod) : SUM_W'(comp_a) + signed'(prod);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psap_pkg::ST_IDLE: begin
            if (!job_empty) begin
               state_in = job_data.crossing ? psap_pkg::ST_DIV : psap_pkg::ST_EMIT_V;
            end
         end
         psap_pkg::ST_DIV: begin
            if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
               state_in = psap_pkg::ST_MUL;
            end
         end
         psap_pkg::ST_MUL: state_in = psap_pkg::ST_ADD;
         psap_pkg::ST_ADD: begin
            state_in = (comp_ff == 2'd2) ? psap_pkg::ST_EMIT_X : psap_pkg::ST_MUL;
         end
         psap_pkg::ST_EMIT_X: begin
            if (!rsp_full) begin
               state_in = psap_pkg::ST_EMIT_V;
            end
         end
         psap_pkg::ST_EMIT_V: begin
            if (!rsp_full) begin
               state_in = psap_pkg::ST_IDLE;
            end
         end
         default: state_in = psap_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      job_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_data = '0;
      unique case (state_ff)
         psap_pkg::ST_IDLE: job_pop = !job_empty;
         psap_pkg::ST_EMIT_X: begin
            rsp_push               = 1'b1;
            rsp_data.point_x       = point_ff[0];
            rsp_data.point_y       = point_ff[1];
            rsp_data.point_z       = point_ff[2];
            rsp_data.to_below_list = 1'b1;
            rsp_data.to_above_list = 1'b1;
            rsp_data.last_of_run   = 1'b0;
         end
         psap_pkg::ST_EMIT_V: begin
            rsp_push               = 1'b1;
            rsp_data.point_x       = job_ff.cur_pt[0];
            rsp_data.point_y       = job_ff.cur_pt[1];
            rsp_data.point_z       = job_ff.cur_pt[2];
            rsp_data.to_below_list = job_ff.to_below;
            rsp_data.to_above_list = job_ff.to_above;
            rsp_data.last_of_run   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psap_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         psap_pkg::ST_IDLE: begin
            job_ff  <= job_data;
            rem_ff  <= DEN_W'(job_data.mag_a);
            den_ff  <= DEN_W'(job_data.mag_a) + DEN_W'(job_data.mag_b);
            t_ff    <= '0;
            cnt_ff  <= '0;
            comp_ff <= 2'd0;
         end
         psap_pkg::ST_DIV: begin
            // One quotient bit per cycle, restoring form.
            rem_ff <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
            t_ff   <= {t_ff[FRAC_BITS-2:0], rem_ge};
            cnt_ff <= cnt_ff + 1'b1;
         end
         psap_pkg::ST_MUL: begin
            prod_hi_ff <= PH_W'(diff_mag[CW:FRAC_BITS]) * PH_W'(t_ff);
            prod_lo_ff <= PL_W'(diff_mag[FRAC_BITS-1:0]) * PL_W'(t_ff);
            neg_ff     <= diff[CW];
         end
         psap_pkg::ST_ADD: begin
            point_ff[comp_ff] <= lerp[CW-1:0];
            comp_ff           <= comp_ff + 1'b1;
         end
         default: ;
      endcase
   end

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psap_pkg::ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder reached the divisor");

   a_comp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psap_pkg::ST_MUL || state_ff == psap_pkg::ST_ADD) |-> (comp_ff != 2'd3))
      else $error("component index out of range");

   a_pop_starts_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (state_ff == psap_pkg::ST_DIV || state_ff == psap_pkg::ST_EMIT_V))
      else $error("popped job did not start");

endmodule

// ----- test/polygon_split_by_axis_plane_core_tb.sv -----
module polygon_split_by_axis_plane_core_tb;

   // The watchdog limit is several times the slowest legal run. That run has every vertex
   // crossing, two result beats per vertex, each waiting out the longest receiver stall,
   // and the longest gap before every input beat.
   localparam int CYCLE_LIMIT   = 400000;
   // Quiet time before a register write and at the end. Seed beats never reach the back
   // end, so once every expected point is back the block is idle; the margin only keeps
   // register writes well clear of the last beat.
   localparam int SETTLE_CYCLES = 4 * (psap_pkg::FRAC_BITS_DEF + 10);
   localparam int PHASE_BEATS   = 230;
   localparam int RANDOM_PHASES = 8;
   localparam int REPORT_CAP    = 100;

   // Axis code two is z, and code three acts as z as well.
   localparam logic [psap_pkg::AXIS_W-1:0]    AXIS_Z       = 2'd2;
   localparam logic [psap_pkg::AXIS_W-1:0]    AXIS_Z_ALIAS = 2'd3;
   // Register index that names no register.
   localparam logic [psap_pkg::CSR_IDX_W-1:0] CSR_UNUSED   = 2'd3;

   // Scoreboard: a bit-exact predictor of the splitter plus the queue of result beats it
   // expects. The predictor keeps its own copy of the registers and of the previous vertex.
   class split_scoreboard;
      logic [psap_pkg::AXIS_W-1:0]          axis_sel;
      logic signed [psap_pkg::OFFSET_W-1:0] plane_pos;
      logic [psap_pkg::BAND_W-1:0]          on_band;
      longint                               last_x, last_y, last_z;
      psap_pkg::class_type                  last_class;
      psap_pkg::rsp_type                    expected_points[$];
      int                                   errors;
      int                                   checked;
      int                                   crossings;
      int                                   seeds;
      int                                   vertices;

      function new();
         axis_sel   = psap_pkg::AXIS_X;
         plane_pos  = '0;
         on_band    = 16'd1;
         last_x     = 0;
         last_y     = 0;
         last_z     = 0;
         last_class = psap_pkg::CLS_ON;
         errors     = 0;
         checked    = 0;
         crossings  = 0;
         seeds      = 0;
         vertices   = 0;
      endfunction

      function void write_reg(logic [psap_pkg::CSR_IDX_W-1:0] idx,
                              logic [psap_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            psap_pkg::CSR_SPLIT_AXIS:   axis_sel  = value[psap_pkg::AXIS_W-1:0];
            psap_pkg::CSR_PLANE_OFFSET: plane_pos = value[psap_pkg::OFFSET_W-1:0];
            psap_pkg::CSR_ZERO_BAND:    on_band   = value[psap_pkg::BAND_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      function void add_expected(psap_pkg::rsp_type pt);
         expected_points.insert(expected_points.size(), pt);
      endfunction

      // Signed distance from the plane along the selected axis. Axis code three is z.
      function longint plane_side(longint x, longint y, longint z);
         longint c;
         case (axis_sel)
            psap_pkg::AXIS_X: c = x;
            psap_pkg::AXIS_Y: c = y;
            default:          c = z;
         endcase
         return c - longint'(plane_pos);
      endfunction

      function longint mag(longint v);
         return (v < 0) ? -v : v;
      endfunction

      function psap_pkg::class_type side_class(longint s);
         if (s == 0 || mag(s) < longint'({1'b0, on_band}))
            return psap_pkg::CLS_ON;
         return (s > 0) ? psap_pkg::CLS_ABOVE : psap_pkg::CLS_BELOW;
      endfunction

      // a + (b - a) * t / 2^FRAC, with the product rounded toward zero.
      function longint blend(longint a, longint b, longint t);
         longint d, ad, hi, lo, prod;
         d    = b - a;
         ad   = mag(d);
         hi   = ad >> psap_pkg::FRAC_BITS_DEF;
         lo   = ad & ((longint'(1) << psap_pkg::FRAC_BITS_DEF) - 1);
         prod = hi * t + ((lo * t) >> psap_pkg::FRAC_BITS_DEF);
         return (d < 0) ? a - prod : a + prod;
      endfunction

      function void note_vertex(psap_pkg::req_type beat);
         longint              bx, by, bz, sa, sb, r, den, t;
         psap_pkg::class_type cb;
         logic                crossing;
         psap_pkg::rsp_type   pt;
         int                  i;
         bx = longint'($signed(beat.vertex_x));
         by = longint'($signed(beat.vertex_y));
         bz = longint'($signed(beat.vertex_z));
         sb = plane_side(bx, by, bz);
         cb = side_class(sb);
         if (beat.opcode == psap_pkg::OP_VERTEX) begin
            vertices++;
            crossing = (cb == psap_pkg::CLS_ABOVE && last_class == psap_pkg::CLS_BELOW) ||
                       (cb == psap_pkg::CLS_BELOW && last_class == psap_pkg::CLS_ABOVE);
            if (crossing) begin
               // The previous side is re-formed under the present register values.
               sa  = plane_side(last_x, last_y, last_z);
               r   = mag(sa);
               den = r + mag(sb);
               t   = 0;
               for (i = 0; i < psap_pkg::FRAC_BITS_DEF; i++) begin
                  r = r << 1;
                  t = t << 1;
                  if (r >= den) begin
                     r = r - den;
                     t = t | 1;
                  end
               end
               pt.point_x       = 32'(blend(last_x, bx, t));
               pt.point_y       = 32'(blend(last_y, by, t));
               pt.point_z       = 32'(blend(last_z, bz, t));
               pt.to_below_list = 1'b1;
               pt.to_above_list = 1'b1;
               pt.last_of_run   = 1'b0;
               add_expected(pt);
               crossings++;
            end
            pt.point_x       = beat.vertex_x;
            pt.point_y       = beat.vertex_y;
            pt.point_z       = beat.vertex_z;
            pt.to_below_list = (cb != psap_pkg::CLS_ABOVE);
            pt.to_above_list = (cb != psap_pkg::CLS_BELOW);
            pt.last_of_run   = 1'b1;
            add_expected(pt);
         end else begin
            seeds++;
         end
         last_x     = bx;
         last_y     = by;
         last_z     = bz;
         last_class = cb;
      endfunction

      // Past the reporting cap, mismatches are still counted but no longer printed.
      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_CAP)
               $error("%s: expected 'h%08h, got 'h%08h", field, want, got);
         end
      endfunction

      function void check_point(psap_pkg::rsp_type got);
         psap_pkg::rsp_type want;
         if (expected_points.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $error("result beat 'h%0h arrived with no expected point waiting", got);
            return;
         end
         want = expected_points.pop_front();
         checked++;
         compare("point_x", want.point_x, got.point_x);
         compare("point_y", want.point_y, got.point_y);
         compare("point_z", want.point_z, got.point_z);
         compare("to_below_list", 32'(want.to_below_list), 32'(got.to_below_list));
         compare("to_above_list", 32'(want.to_above_list), 32'(got.to_above_list));
         compare("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_push;
   logic                                 req_full;
   psap_pkg::req_type                    req_data;
   logic                                 rsp_empty;
   logic                                 rsp_pop;
   psap_pkg::rsp_type                    rsp_data;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [psap_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [psap_pkg::CSR_DATA_W-1:0]      csr_data;

   split_scoreboard sb = new();
   int  cycles = 0;
   int  settings = 0;
   // When set, the matching side runs without gaps for the whole phase.
   bit  push_steady = 1'b0;
   bit  pop_steady = 1'b0;

   polygon_split_by_axis_plane_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog. A hang anywhere, including results that never drain, ends here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side. A beat is taken at an edge where pop is high and empty is low; the
   // values read just after the edge are those the block presented at it. After each
   // beat the receiver may hold pop low for a random stall, so stalls land on every phase
   // of the back end, including the two beats of a crossing vertex.
   initial begin : result_drain
      int stall;
      do @(posedge clock); while (reset);
      rsp_pop <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            sb.check_point(rsp_data);
            stall = pop_steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
               rsp_pop <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_pop <= 1'b1;
            end
         end
      end
   end

   // Sends one input beat. Push is left high after acceptance, so that a following beat
   // with no gap goes out back to back; the caller lowers it when a run of beats ends.
   task automatic push_item(input psap_pkg::req_type beat);
      int gap;
      gap = push_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_vertex(beat);
   endtask

   // Waits until every expected point has come back, then idles a while longer.
   task automatic settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes go back to back; valid drops once after the last one. Upper data
   // bits beyond a register's width carry noise, which the block must drop.
   task automatic write_csr(input logic [psap_pkg::CSR_IDX_W-1:0] idx,
                            input logic [psap_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic set_plane(input logic [psap_pkg::AXIS_W-1:0] axis, input logic [31:0] offset,
                            input logic [psap_pkg::BAND_W-1:0] band, input bit stray_write);
      write_csr(psap_pkg::CSR_SPLIT_AXIS, {30'($urandom_range(0, 32'h3FFF_FFFF)), axis});
      write_csr(psap_pkg::CSR_PLANE_OFFSET, offset);
      write_csr(psap_pkg::CSR_ZERO_BAND, {16'($urandom), band});
      // A write to an index that names no register must leave every setting unchanged.
      if (stray_write)
         write_csr(CSR_UNUSED, $urandom);
      csr_valid <= 1'b0;
      settings++;
   endtask

   function automatic psap_pkg::req_type vtx(logic op, logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z);
      psap_pkg::req_type beat;
      beat.opcode   = op;
      beat.vertex_x = x;
      beat.vertex_y = y;
      beat.vertex_z = z;
      return beat;
   endfunction

   function automatic logic [31:0] small_signed(int max_bits);
      logic [31:0] v;
      v = $urandom_range(0, 1 << $urandom_range(0, max_bits));
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   // Coordinate on the split axis. Most land close to the plane, so the zero band, its
   // exact boundary and short crossing edges all come up; some are exactly on the plane
   // and some are anywhere in the full range.
   function automatic logic [31:0] axis_coord();
      logic [31:0] pos, band;
      pos  = sb.plane_pos;
      band = {16'd0, sb.on_band};
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2:       return pos;
         3:       return pos + band;
         4:       return pos - band;
         5:       return $urandom_range(0, 1) ? pos + band - 1 : pos - band + 1;
         default: return pos + small_signed(24);
      endcase
   endfunction

   function automatic psap_pkg::req_type make_vertex();
      psap_pkg::req_type beat;
      beat.opcode   = psap_pkg::OP_VERTEX;
      beat.vertex_x = $urandom_range(0, 1) ? 32'($urandom) : small_signed(22);
      beat.vertex_y = $urandom_range(0, 1) ? 32'($urandom) : small_signed(22);
      beat.vertex_z = $urandom_range(0, 1) ? 32'($urandom) : small_signed(22);
      case (sb.axis_sel)
         psap_pkg::AXIS_X: beat.vertex_x = axis_coord();
         psap_pkg::AXIS_Y: beat.vertex_y = axis_coord();
         default:          beat.vertex_z = axis_coord();
      endcase
      return beat;
   endfunction

   // A well-formed polygon is its closing vertex as a seed, then its vertices in order,
   // ending on the closing vertex again. A few polygons lose their seed or stop early.
   task automatic send_polygon(output int sent);
      psap_pkg::req_type ring[8];
      psap_pkg::req_type seed;
      int                n, stop, i;
      n = $urandom_range(3, 8);
      for (i = 0; i < n; i++)
         ring[i] = make_vertex();
      stop = ($urandom_range(0, 15) == 0) ? $urandom_range(1, n) : n;
      sent = 0;
      if ($urandom_range(0, 15) != 0) begin
         seed = ring[n-1];
         seed.opcode = psap_pkg::OP_SEED;
         push_item(seed);
         sent++;
      end
      for (i = 0; i < stop; i++) begin
         push_item(ring[i]);
         sent++;
      end
   endtask

   task automatic run_phase(input int beats);
      int                sent, k, i;
      psap_pkg::req_type beat;
      push_steady = ($urandom_range(0, 3) == 0);
      pop_steady  = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < beats) begin
         if ($urandom_range(0, 9) < 8) begin
            send_polygon(k);
            sent += k;
         end else begin
            // Noise: loose beats with either opcode.
            k = $urandom_range(1, 4);
            for (i = 0; i < k; i++) begin
               beat = make_vertex();
               beat.opcode = $urandom_range(0, 1) ? psap_pkg::OP_VERTEX : psap_pkg::OP_SEED;
               push_item(beat);
            end
            sent += k;
         end
      end
      req_push <= 1'b0;
      settle();
   endtask

   initial begin : stimulus
      int          p;
      logic [31:0] offset;
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      rsp_pop   = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset registers: x axis, plane at zero, band of one LSB.
      // The first vertex comes before any seed, against the origin on the plane.
      push_item(vtx(psap_pkg::OP_VERTEX, 32'h0003_0000, 32'hFFFF_FFFB, 32'h0000_0007));
      // Exactly on the plane, then a side of one LSB (not under the band), then a
      // crossing back over with the smallest possible sides.
      push_item(vtx(psap_pkg::OP_VERTEX, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      push_item(vtx(psap_pkg::OP_VERTEX, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0001));
      push_item(vtx(psap_pkg::OP_VERTEX, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF));
      // Full-range edges from below to above and back, corner to corner.
      push_item(vtx(psap_pkg::OP_SEED, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      push_item(vtx(psap_pkg::OP_VERTEX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      push_item(vtx(psap_pkg::OP_VERTEX, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      push_item(vtx(psap_pkg::OP_VERTEX, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      // A seed above, then a crossing to -2^16, onto the plane and off again.
      push_item(vtx(psap_pkg::OP_SEED, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000));
      push_item(vtx(psap_pkg::OP_VERTEX, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF));
      push_item(vtx(psap_pkg::OP_VERTEX, 32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA));
      push_item(vtx(psap_pkg::OP_VERTEX, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555));
      push_item(vtx(psap_pkg::OP_SEED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
      push_item(vtx(psap_pkg::OP_VERTEX, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000));
      req_push <= 1'b0;
      settle();

      // Random phases. The first three pin the register extremes: y axis with the plane
      // at the top of the range and the widest band, z axis at the bottom with no band
      // (only an exact zero is on the plane), and axis code three, which acts as z.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: set_plane(psap_pkg::AXIS_Y, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
            1: set_plane(AXIS_Z, 32'h8000_0000, 16'h0000, 1'b0);
            2: set_plane(AXIS_Z_ALIAS, small_signed(24), 16'($urandom_range(0, 255)), 1'b1);
            default: begin
               offset = $urandom_range(0, 1) ? 32'($urandom) : small_signed(24);
               set_plane(($urandom_range(0, 5) == 0) ? AXIS_Z_ALIAS : 2'($urandom_range(0, 2)),
                         offset,
                         $urandom_range(0, 1) ? 16'($urandom_range(0, 64)) : 16'($urandom),
                         $urandom_range(0, 3) == 0);
            end
         endcase
         run_phase(PHASE_BEATS);
      end

      $display("Sent %0d vertex beats and %0d seed beats; checked %0d result beats, %0d of them",
               sb.vertices, sb.seeds, sb.checked, sb.crossings);
      $display("intersection points, over %0d register settings plus the reset values.",
               settings);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/psap_pkg.sv
hw/rtl/psap_fifo.sv
hw/rtl/psap_front.sv
hw/rtl/psap_back.sv
hw/rtl/polygon_split_by_axis_plane_core.sv
test/polygon_split_by_axis_plane_core_tb.sv
